@@ sv/tridiagonal_system_solver_assert.svh @@
// Assertion macros for the tridiagonal solver.
// Used by the top level only; no other dependencies.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_ASSERT_SVH
// implication checked every clock outside reset
`define TDS_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("tds assertion failed");
// next-cycle implication
`define TDS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("tds assertion failed");
`endif

@@ sv/tds_pkg.sv @@
// Package for the tridiagonal solver: payload types, status codes, states.
// No dependencies.
`default_nettype none
package tds_pkg;
   localparam int MaxRowsDefault  = 64;
   localparam int FracBitsDefault = 16;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SINGULAR = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] sub_diag;
      logic signed [31:0] main_diag;
      logic signed [31:0] super_diag;
      logic signed [31:0] rhs_value;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic [5:0]         row_index;
      logic signed [31:0] solution;
      logic [1:0]         status;
      logic               last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRD,     // read previous row
      ST_FDIV,    // divide sub by pivot
      ST_FMUL1,   // l * upper
      ST_FMUL2,   // l * forward
      ST_FWR,     // store row
      ST_BRD,     // read row for back-substitution
      ST_BMUL,    // s * x
      ST_BDIV,    // divide by pivot
      ST_BOUT,    // emit
      ST_FAIL
   } state_type;
endpackage
`default_nettype wire

@@ sv/tridiagonal_system_solver.sv @@
// Top level of the tridiagonal solver (Thomas algorithm), with its sequencer,
// shared divider and multiplier. Depends on tds_pkg and the assert header.
`default_nettype none
`include "tridiagonal_system_solver_assert.svh"
// Usage:
//  req_ channel: drive req_data and raise start; the row is taken on an edge
//  where start is high and busy is low. busy stays high while a row is at work.
//  Each row after the first runs a radix-2 restoring divide of (FRAC_BITS+33)
//  steps for the multiplier, then the multiplies l*upper and l*forward and a store
//  (values are Q16.16 at the default FRAC_BITS); the first row skips them but the store.
//  On the row marked last_row, back-substitution walks the stored rows from
//  the last down to row 0; the last row divides straight from the registers,
//  every other row takes a memory read, a multiply, the divide and an output.
//  Results appear on rsp_data for one cycle with rsp_valid high; the receiver
//  cannot stall, so every result is dropped on the port exactly once.
//  A singular or overflowed system gives one result with status 1 or 2.
//  csr_ channel: csr_ready is high while the block is idle and start is low;
//  a write sets pivot_epsilon (reset value 1).
//  Reset clears the row count, the error flags and the sequencer; the row
//  stores hold no reset value and need no clearing pass.
module tridiagonal_system_solver #(
   parameter int MAX_ROWS  = tds_pkg::MaxRowsDefault,
   parameter int FRAC_BITS = tds_pkg::FracBitsDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire tds_pkg::req_type req_data,
   output logic                 rsp_valid,
   output tds_pkg::rsp_type     rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [15:0]          csr_data
);
   import tds_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int NW = 32 + FRAC_BITS + 1;     // shifted numerator width
   localparam int DSTEPS = NW;
   localparam int SW = $clog2(DSTEPS + 1);
   localparam logic signed [63:0] QMAX = 64'sd2147483647;
   localparam logic signed [63:0] QMIN = -64'sd2147483648;

   // row stores
   logic signed [31:0] piv_mem [MAX_ROWS];
   logic signed [31:0] fwd_mem [MAX_ROWS];
   logic signed [31:0] upp_mem [MAX_ROWS];
   logic signed [31:0] piv_rd_ff, fwd_rd_ff, upp_rd_ff;
   logic [IW-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic sing_ff, sing_in, ovf_ff, ovf_in;
   logic [15:0] eps_ff;
   req_type row_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic signed [31:0] l_ff, l_in, x_ff, x_in;
   logic signed [31:0] u_ff, u_in;
   logic wr_en;
   logic signed [31:0] wr_u, wr_y;

   // divider state
   logic [NW-1:0] dq_ff, dq_in;          // numerator shifting into quotient
   logic [33:0]   dr_ff, dr_in;          // partial remainder
   logic [32:0]   dd_ff, dd_in;          // 2*|d|
   logic          dneg_ff, dneg_in, dzero_ff, dzero_in, dnpos_ff, dnpos_in;
   logic [SW-1:0] dcnt_ff, dcnt_in;

   // saturate helper
   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > QMAX) return 32'sh7fffffff;
      if (v < QMIN) return 32'sh80000000;
      return v[31:0];
   endfunction

   // rounded Q product, shared multiplier
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0] m;
      logic [63:0] r;
      p = 64'(a) * 64'(b);
      m = p[63] ? (64'd0 - 64'(p)) : 64'(p);
      r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return sat(p[63] ? -$signed(r) : $signed(r));
   endfunction

   logic signed [31:0] mul_a, mul_b, mul_p;
   assign mul_p = qmul(mul_a, mul_b);

   // divider start values: numerator n, denominator d
   logic signed [31:0] dv_n, dv_d;
   logic dv_go;
   logic [32:0] mag_n, mag_d;
   assign mag_n = dv_n[31] ? 33'd0 - 33'(dv_n) : 33'(dv_n);
   assign mag_d = dv_d[31] ? 33'd0 - 33'(dv_d) : 33'(dv_d);

   // q = (|n|<<(F+1) + |d|) / (2|d|); numerator = |n|<<(F+1) + |d|, width NW+1
   logic [NW:0] dnum;
   assign dnum = ({(NW+1-33)'(0), mag_n} << (FRAC_BITS + 1)) + (NW+1)'(mag_d);

   logic [34:0] trial;
   logic [33:0] shifted;
   logic        dv_done;
   logic signed [31:0] dv_q;
   logic signed [63:0] qs;
   assign shifted = {dr_ff[32:0], dq_ff[NW-1]};
   assign trial = {1'b0, shifted} - {2'b0, dd_ff};
   assign dv_done = (dcnt_ff == '0);
   always_comb begin
      qs = dneg_ff ? -$signed({{(64-NW){1'b0}}, dq_ff}) : $signed({{(64-NW){1'b0}}, dq_ff});
      if (dzero_ff) dv_q = dnpos_ff ? 32'sh7fffffff : (dneg_ff ? 32'sh80000000 : 32'sd0);
      else dv_q = sat(qs);
   end

   // divider iteration
   always_comb begin
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dcnt_in = dcnt_ff;
      dneg_in = dneg_ff; dzero_in = dzero_ff; dnpos_in = dnpos_ff;
      if (dv_go) begin
         // top bit of dnum is zero for 32-bit magnitudes
         dq_in = dnum[NW-1:0];
         dr_in = '0;
         dd_in = {mag_d[31:0], 1'b0};
         dcnt_in = SW'(DSTEPS);
         dzero_in = (dv_d == 32'sd0);
         dnpos_in = !dv_n[31] && (dv_n != 32'sd0);
         dneg_in = (dv_d == 32'sd0) ? dv_n[31] : (dv_n[31] ^ dv_d[31]);
      end else if (!dv_done) begin
         if (!trial[34]) begin
            dr_in = trial[33:0];
            dq_in = {dq_ff[NW-2:0], 1'b1};
         end else begin
            dr_in = shifted;
            dq_in = {dq_ff[NW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   logic [32:0] u_mag;
   assign u_mag = wr_u[31] ? 33'd0 - 33'(wr_u) : 33'(wr_u);

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; sing_in = sing_ff; ovf_in = ovf_ff;
      idx_in = idx_ff; l_in = l_ff; x_in = x_ff; u_in = u_ff;
      wr_en = 1'b0; wr_u = u_ff; wr_y = 32'sd0;
      dv_go = 1'b0; dv_n = 32'sd0; dv_d = 32'sd0;
      mul_a = l_ff; mul_b = upp_rd_ff;
      rd_addr = idx_ff;
      rsp_valid = 1'b0;
      rsp_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = IW'(count_ff - 1'b1);
            if (start) begin
               if (count_ff >= CW'(MAX_ROWS)) begin
                  ovf_in = 1'b1;
                  state_in = req_data.last_row ? ST_FAIL : ST_IDLE;
               end else begin
                  state_in = ST_FRD;
               end
            end
         end
         ST_FRD: begin
            if (count_ff == '0) begin
               wr_u = row_ff.main_diag; wr_y = row_ff.rhs_value; state_in = ST_FWR;
               u_in = row_ff.main_diag; x_in = row_ff.rhs_value;
            end else begin
               dv_go = 1'b1; dv_n = row_ff.sub_diag; dv_d = piv_rd_ff;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: if (dv_done) begin
            l_in = dv_q; state_in = ST_FMUL1;
         end
         ST_FMUL1: begin
            u_in = sat(64'(row_ff.main_diag) - 64'(mul_p));
            state_in = ST_FMUL2;
         end
         ST_FMUL2: begin
            mul_b = fwd_rd_ff;
            x_in = sat(64'(row_ff.rhs_value) - 64'(mul_p));
            state_in = ST_FWR;
         end
         ST_FWR: begin
            wr_en = 1'b1; wr_u = u_ff; wr_y = x_ff;
            if (u_mag < 33'(eps_ff)) sing_in = 1'b1;
            count_in = count_ff + 1'b1;
            idx_in = IW'(count_ff);
            if (!row_ff.last_row) state_in = ST_IDLE;
            else if (ovf_ff || sing_in) state_in = ST_FAIL;
            else begin
               // last row: x = y / u straight from the registers
               dv_go = 1'b1; dv_n = x_ff; dv_d = u_ff;
               state_in = ST_BDIV;
            end
         end
         ST_BRD: begin
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            mul_a = upp_rd_ff; mul_b = x_ff;
            dv_go = 1'b1; dv_n = sat(64'(fwd_rd_ff) - 64'(mul_p)); dv_d = piv_rd_ff;
            state_in = ST_BDIV;
         end
         ST_BDIV: if (dv_done) begin
            x_in = dv_q; state_in = ST_BOUT;
         end
         ST_BOUT: begin
            rsp_valid = 1'b1;
            rsp_data.row_index = 6'(idx_ff);
            rsp_data.solution = x_ff;
            rsp_data.status = STATUS_OK;
            rsp_data.last_result = (idx_ff == '0);
            if (idx_ff == '0) begin
               count_in = '0; sing_in = 1'b0; ovf_in = 1'b0; state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1; rd_addr = idx_ff - 1'b1; state_in = ST_BRD;
            end
         end
         ST_FAIL: begin
            rsp_valid = 1'b1;
            rsp_data.row_index = '0;
            rsp_data.solution = '0;
            rsp_data.status = ovf_ff ? STATUS_OVERFLOW : STATUS_SINGULAR;
            rsp_data.last_result = 1'b1;
            count_in = '0; sing_in = 1'b0; ovf_in = 1'b0; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; sing_ff <= 1'b0; ovf_ff <= 1'b0;
         eps_ff <= 16'd1; dcnt_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; sing_ff <= sing_in; ovf_ff <= ovf_in;
         dcnt_ff <= dcnt_in;
         if (csr_valid && csr_ready) eps_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) row_ff <= req_data;
      idx_ff <= idx_in; l_ff <= l_in; x_ff <= x_in; u_ff <= u_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in;
      dneg_ff <= dneg_in; dzero_ff <= dzero_in; dnpos_ff <= dnpos_in;
   end

   // memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         piv_mem[IW'(count_ff)] <= wr_u;
         fwd_mem[IW'(count_ff)] <= wr_y;
         upp_mem[IW'(count_ff)] <= row_ff.super_diag;
      end
      piv_rd_ff <= piv_mem[rd_addr];
      fwd_rd_ff <= fwd_mem[rd_addr];
      upp_rd_ff <= upp_mem[rd_addr];
   end

   // assertions
   `TDS_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, busy)
   `TDS_ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_data.last_result, !busy)
   `TDS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MAX_ROWS))
endmodule
`default_nettype wire

@@ test/tridiagonal_system_solver_tb.sv @@
// Self-checking testbench for the tridiagonal solver: directed rows, an overflow test, then random systems.
// A fixed-point Thomas algorithm predictor, or a typed expected result, checks every result. Depends on tds_pkg.
`default_nettype none
module tridiagonal_system_solver_tb;
   import tds_pkg::*;

   localparam int  MaxRows   = 64;
   localparam int  WatchLim  = 20000;
   localparam int  SettleCyc = 120;
   localparam longint QMax   = 64'sd2147483647;
   localparam longint QMin   = -64'sd2147483648;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   tridiagonal_system_solver uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // solver model state
   longint      pivot_q[MaxRows];
   longint      fwd_q[MaxRows];
   longint      upper_q[MaxRows];
   int          rows_held;
   bit          sing_flag, ovf_flag;
   logic [15:0] eps_model = 16'd1;
   rsp_type     solution_fifo[$];
   int          errors = 0;

   // directed stimulus table
   typedef struct {
      req_type row;
      bit      write_eps;
      logic [15:0] eps;
      bit      typed;
      rsp_type result;
   } dir_entry_type;
   dir_entry_type dir_rows[$];

   // append one expected result
   function automatic void queue_rsp(rsp_type r);
      solution_fifo = {solution_fifo, r};
   endfunction

   function automatic longint sat32(longint v);
      if (v > QMax) return QMax;
      if (v < QMin) return QMin;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = ((p < 0 ? -p : p) + 64'sd32768) >>> 16;
      return sat32(p < 0 ? -m : m);
   endfunction

   function automatic longint qdiv(longint n, longint d);
      longint mn, md, q;
      if (d == 0) return (n > 0) ? QMax : (n < 0) ? QMin : 0;
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      q = ((mn <<< 17) + md) / (md * 2);
      return sat32(((n < 0) != (d < 0)) ? -q : q);
   endfunction

   function automatic rsp_type mk_rsp(int idx, longint x, status_type st, bit lst);
      rsp_type r;
      r.row_index   = idx[5:0];
      r.solution    = x[31:0];
      r.status      = st;
      r.last_result = lst;
      return r;
   endfunction

   // forward elimination per row; back-substitution on the last row
   task automatic solve_row(req_type rq, bit keep);
      longint u, y, l, x, t;
      int j, n;
      if (rows_held >= MaxRows) begin
         ovf_flag = 1;
      end else begin
         j = rows_held;
         if (j == 0) begin
            u = rq.main_diag;
            y = rq.rhs_value;
         end else begin
            l = qdiv(longint'(rq.sub_diag), pivot_q[j-1]);
            u = sat32(longint'(rq.main_diag) - qmul(l, upper_q[j-1]));
            y = sat32(longint'(rq.rhs_value) - qmul(l, fwd_q[j-1]));
         end
         if ((u < 0 ? -u : u) < longint'(eps_model)) sing_flag = 1;
         pivot_q[j] = u;
         fwd_q[j]   = y;
         upper_q[j] = rq.super_diag;
         rows_held  = j + 1;
      end
      if (!rq.last_row) return;
      if (keep) begin
         if (ovf_flag)
            queue_rsp(mk_rsp(0, 0, STATUS_OVERFLOW, 1'b1));
         else if (sing_flag)
            queue_rsp(mk_rsp(0, 0, STATUS_SINGULAR, 1'b1));
         else begin
            n = rows_held;
            x = qdiv(fwd_q[n-1], pivot_q[n-1]);
            queue_rsp(mk_rsp(n-1, x, STATUS_OK, n == 1));
            for (int i = n - 2; i >= 0; i--) begin
               t = sat32(fwd_q[i] - qmul(upper_q[i], x));
               x = qdiv(t, pivot_q[i]);
               queue_rsp(mk_rsp(i, x, STATUS_OK, i == 0));
            end
         end
      end
      rows_held = 0;
      sing_flag = 0;
      ovf_flag  = 0;
   endtask

   function automatic int rand_gap();
      return ($urandom_range(9, 0) == 0) ? $urandom_range(60, 5) :
             ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(3, 1);
   endfunction

   // one row transaction; start stays high across back-to-back rows
   task automatic send_row(req_type rq, bit typed, rsp_type tres);
      int gap;
      gap = rand_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      solve_row(rq, !typed);
      if (typed) queue_rsp(tres);
   endtask

   // register write only once the block has drained
   task automatic write_eps(logic [15:0] v);
      start <= 1'b0;
      wait (solution_fifo.size() == 0);
      repeat (SettleCyc) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eps_model = v;
   endtask

   function automatic req_type mk_req(logic [31:0] c, logic [31:0] a, logic [31:0] s,
                                      logic [31:0] r, bit lst);
      req_type q;
      q.sub_diag = c; q.main_diag = a; q.super_diag = s; q.rhs_value = r; q.last_row = lst;
      return q;
   endfunction

   function automatic void add_dir(req_type rq, bit we, logic [15:0] ev, bit typed,
                                   rsp_type res);
      dir_entry_type e;
      e.row = rq; e.write_eps = we; e.eps = ev; e.typed = typed; e.result = res;
      dir_rows = {dir_rows, e};
   endfunction

   // well-conditioned row most of the time, raw bits otherwise
   function automatic req_type rand_row(bit lst, bit noisy);
      req_type q;
      if (noisy) begin
         q = mk_req($urandom, $urandom, $urandom, $urandom, lst);
      end else begin
         q.sub_diag   = $signed($urandom_range(131072, 0)) - 65536;
         q.super_diag = $signed($urandom_range(131072, 0)) - 65536;
         q.main_diag  = $signed($urandom_range(600000, 200000)) * ($urandom_range(1, 0) ? 1 : -1);
         q.rhs_value  = $signed($urandom_range(8000000, 0)) - 4000000;
         q.last_row   = lst;
      end
      return q;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (solution_fifo.size() == 0) begin
            $error("unexpected result: row_index %0d", rsp_data.row_index);
            errors++;
         end else begin
            e = solution_fifo.pop_front();
            if (rsp_data.row_index !== e.row_index) begin
               $error("row_index exp %0d got %0d", e.row_index, rsp_data.row_index);
               errors++;
            end
            if (rsp_data.solution !== e.solution) begin
               $error("solution exp %h got %h", e.solution, rsp_data.solution);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.last_result !== e.last_result) begin
               $error("last_result exp %0d got %0d", e.last_result, rsp_data.last_result);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WatchLim) begin
         $display("[tridiagonal_system_solver] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   localparam logic [31:0] One = 32'h0001_0000;

   initial begin
      rsp_type none;
      int n, kind;
      none = '0;
      rows_held = 0; sing_flag = 0; ovf_flag = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single rows, extremes, singular cases, epsilon limits
      add_dir(mk_req(0, One, 0, 32'h0002_0000, 1'b1), 1'b0, 16'd0, 1'b1,
              mk_rsp(0, 32'h0002_0000, STATUS_OK, 1'b1));
      add_dir(mk_req(0, 0, 0, One, 1'b1), 1'b0, 16'd0, 1'b1,
              mk_rsp(0, 0, STATUS_SINGULAR, 1'b1));
      add_dir(mk_req(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 1'b0),
              1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 1'b1),
              1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(0, 32'h0004_0000, One, One, 1'b0), 1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(One, 32'h0004_0000, One, 32'h0002_0000, 1'b0),
              1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(32'hffff_0000, 32'hfffc_0000, 0, 32'hfffd_0000, 1'b1),
              1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(0, 0, One, One, 1'b0), 1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(One, 32'h0003_0000, 0, One, 1'b1), 1'b0, 16'd0, 1'b1,
              mk_rsp(0, 0, STATUS_SINGULAR, 1'b1));
      add_dir(mk_req(0, 0, 0, 32'h0000_0005, 1'b1), 1'b1, 16'd0, 1'b1,
              mk_rsp(0, QMax, STATUS_OK, 1'b1));
      add_dir(mk_req(0, 0, 0, 0, 1'b1), 1'b0, 16'd0, 1'b1,
              mk_rsp(0, 0, STATUS_OK, 1'b1));
      add_dir(mk_req(0, 0, 0, 32'hffff_fffb, 1'b1), 1'b0, 16'd0, 1'b1,
              mk_rsp(0, QMin, STATUS_OK, 1'b1));
      add_dir(mk_req(0, One, 0, One, 1'b0), 1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(One, One, 0, One, 1'b1), 1'b0, 16'd0, 1'b0, none);
      add_dir(mk_req(0, 32'h0000_fffe, 0, One, 1'b1), 1'b1, 16'hffff, 1'b1,
              mk_rsp(0, 0, STATUS_SINGULAR, 1'b1));
      add_dir(mk_req(0, 32'hffff_0000, 0, One, 1'b1), 1'b0, 16'd0, 1'b0, none);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].write_eps) write_eps(dir_rows[i].eps);
         send_row(dir_rows[i].row, dir_rows[i].typed, dir_rows[i].result);
      end

      // overflow: two rows past capacity (the second marked last_row), then a clean full-size system
      write_eps(16'd1);
      for (int i = 0; i < MaxRows + 1; i++) send_row(rand_row(1'b0, 1'b0), 1'b0, none);
      send_row(rand_row(1'b1, 1'b0), 1'b0, none);
      for (int i = 0; i < MaxRows; i++)
         send_row(rand_row(i == MaxRows - 1, 1'b0), 1'b0, none);

      // random systems, mostly small, epsilon changed between phases
      for (int ph = 0; ph < 4; ph++) begin
         write_eps(ph == 3 ? 16'd0 : 16'($urandom_range(65535, 0)));
         for (int sys = 0; sys < 5; sys++) begin
            n = ($urandom_range(15, 0) == 0) ? $urandom_range(MaxRows, 20)
                                             : $urandom_range(6, 1);
            kind = $urandom_range(9, 0);
            for (int i = 0; i < n; i++)
               send_row(rand_row(i == n - 1, kind == 0 || $urandom_range(19, 0) == 0),
                        1'b0, none);
         end
      end

      start <= 1'b0;
      wait (solution_fifo.size() == 0);
      repeat (SettleCyc) @(posedge clock);
      if (errors == 0)
         $display("[tridiagonal_system_solver] OK");
      else
         $display("[tridiagonal_system_solver] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
